>>> rtl/lpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants for the length-prefixed deframer
// Result record, parser phases, result kinds and queue sizing.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam logic [1:0]  KIND_HEADER = 2'd0;
    localparam logic [1:0]  KIND_BODY   = 2'd1;
    localparam logic [1:0]  KIND_ERROR  = 2'd2;

    localparam logic [31:0] MIN_LEN       = 32'd10;
    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    // last byte index of the length field and of the type/id header
    localparam logic [3:0]  LEN_LAST_IDX = 4'd3;
    localparam logic [3:0]  HDR_LAST_IDX = 4'd9;
    localparam logic [3:0]  TYPE_BYTES   = 4'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2,
        PH_SKIP = 2'd3
    } lpd_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] frame_type;
        logic [63:0] message_id;
        logic [31:0] body_length;
        logic [7:0]  data_byte;
        logic        last;
    } lpd_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lpd_qstat_t;

endpackage

>>> rtl/length_prefixed_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer: length-prefixed frame parser
// Splits a byte stream into header, body-byte and length-error beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one stream byte per beat. Each frame is a 32-bit
//   big-endian length, a 16-bit type, a 64-bit id and the body.
//   m_axis carries one result beat per header, body byte or bad length;
//   tuser gives the kind, tlast marks the final beat of a frame.
//   cfg_wr_en/cfg_wr_data write the maximum declared length; write it idle.
//   Throughput: one byte per cycle while the result queue is not full.
//   A result is registered in the queue and then in the output register
//   before it appears on m_axis.
//   A four-entry queue sits between the parser and the output register;
//   when m_axis stalls the queue fills and s_axis_tready drops only when
//   it is full. Skip bytes produce no beat; length bytes only a bad-length one.
//   Reset: parser waits for a length field, queue and output are empty,
//   the maximum length returns to 1048576.
// ----------------------------------------------------------------------------
module length_prefixed_deframer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,   // max_frame_length
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] in_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] frame_type, [79:16] message_id, [111:80] body_length,
    // [119:112] data_byte
    output logic [119:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // [1:0] result_kind
    output logic         m_axis_tlast   // last
);
    import lpd_pkg::*;

    logic       byte_accept;
    logic       push;
    logic       pop;
    lpd_rec_t   push_rec;
    lpd_rec_t   pop_rec;
    lpd_qstat_t qstat;

    assign s_axis_tready = !qstat.full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    lpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_accept (byte_accept),
        .byte_in     (s_axis_tdata),
        .push        (push),
        .push_rec    (push_rec)
    );

    lpd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .stat     (qstat)
    );

    lpd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec_in        (pop_rec),
        .qstat         (qstat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> rtl/lpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_front: byte parser
// Takes one stream byte per beat, tracks the frame phase and builds a
// result record for header, body and length-error events.
// ----------------------------------------------------------------------------
module lpd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic              byte_accept,
    input  logic [7:0]        byte_in,
    output logic              push,
    output lpd_pkg::lpd_rec_t push_rec
);
    import lpd_pkg::*;

    lpd_phase_t  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] type_reg, type_next;
    logic [63:0] id_reg, id_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] max_reg;

    logic [31:0] len_shift;
    logic [31:0] body_len;

    assign len_shift = {len_reg[23:0], byte_in};
    assign body_len  = len_reg - MIN_LEN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN;
            cnt_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            id_reg    <= '0;
            left_reg  <= '0;
            max_reg   <= MAX_LEN_RESET;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            id_reg    <= id_next;
            left_reg  <= left_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        left_next  = left_reg;
        push       = 1'b0;
        push_rec   = '0;
        if (byte_accept) begin
            unique case (phase_reg)
                PH_LEN: begin
                    len_next = len_shift;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == LEN_LAST_IDX) begin
                        cnt_next = '0;
                        if (len_shift < MIN_LEN || len_shift > max_reg) begin
                            left_next  = len_shift;
                            phase_next = (len_shift != '0) ? PH_SKIP : PH_LEN;
                            len_next   = '0;
                            push       = 1'b1;
                            push_rec.kind = KIND_ERROR;
                            push_rec.last = 1'b1;
                        end else begin
                            type_next  = '0;
                            id_next    = '0;
                            phase_next = PH_HDR;
                        end
                    end
                end
                PH_HDR: begin
                    if (cnt_reg < TYPE_BYTES) begin
                        type_next = {type_reg[7:0], byte_in};
                    end else begin
                        id_next = {id_reg[55:0], byte_in};
                    end
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == HDR_LAST_IDX) begin
                        cnt_next   = '0;
                        left_next  = body_len;
                        len_next   = '0;
                        phase_next = (body_len != '0) ? PH_BODY : PH_LEN;
                        push       = 1'b1;
                        push_rec.kind        = KIND_HEADER;
                        push_rec.frame_type  = type_next;
                        push_rec.message_id  = id_next;
                        push_rec.body_length = body_len;
                        push_rec.last        = (body_len == '0);
                    end
                end
                PH_BODY: begin
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1) begin
                        phase_next = PH_LEN;
                    end
                    push = 1'b1;
                    push_rec.kind      = KIND_BODY;
                    push_rec.data_byte = byte_in;
                    push_rec.last      = (left_reg == 32'd1);
                end
                PH_SKIP: begin
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1) begin
                        phase_next = PH_LEN;
                    end
                end
                default: begin
                    phase_next = PH_LEN;
                end
            endcase
        end
    end

    a_len_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LEN) |-> (cnt_reg <= LEN_LAST_IDX))
        else $error("length byte count out of range");

    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY || phase_reg == PH_SKIP) |-> (left_reg != '0))
        else $error("body or skip phase with no bytes left");

endmodule

>>> rtl/lpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_queue: result queue
// Small register FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module lpd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lpd_pkg::lpd_rec_t   push_rec,
    input  logic                pop,
    output lpd_pkg::lpd_rec_t   pop_rec,
    output lpd_pkg::lpd_qstat_t stat
);
    import lpd_pkg::*;

    lpd_rec_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_rec    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count did not grow on push");

endmodule

>>> rtl/lpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_back: output stage
// Pulls records from the queue into the master-side output register.
// ----------------------------------------------------------------------------
module lpd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lpd_pkg::lpd_rec_t   rec_in,
    input  lpd_pkg::lpd_qstat_t qstat,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [119:0]        m_axis_tdata,
    output logic [1:0]          m_axis_tuser,
    output logic                m_axis_tlast
);
    import lpd_pkg::*;

    logic     valid_reg;
    lpd_rec_t rec_reg;

    assign pop = !qstat.empty && (!valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_axis_tready) begin
            valid_reg <= !qstat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= rec_in;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = rec_reg.kind;
    assign m_axis_tlast  = rec_reg.last;
    assign m_axis_tdata  = {rec_reg.data_byte, rec_reg.body_length,
                            rec_reg.message_id, rec_reg.frame_type};

endmodule

>>> dv/length_prefixed_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer_test: self-checking bench for the frame parser
// Streams length-prefixed frames into the parser one byte per beat. Good
// frames, empty bodies, short and oversized lengths are included. A local
// deframer mirror predicts every header, body-byte and error beat. Results
// are checked in order, field by field. The maximum length is stepped
// through its extremes while the parser is idle. Both sides idle at random.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_test;
    import lpd_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 200;
    localparam int NUM_PHASES   = 8;

    localparam logic [31:0] MAX_SETTINGS [NUM_PHASES] = '{
        MAX_LEN_RESET, 32'd12, 32'hFFFF_FFFF, 32'd0, 32'd9, 32'd10, 32'd64, 32'd300
    };

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic [31:0]  cfg_wr_data   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    always #10 aclk = ~aclk;

    length_prefixed_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [7:0] pending_bytes [$];
    lpd_rec_t   expected_beats [$];
    bit         byte_on_bus    = 1'b0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         errors         = 0;
    int         quiet_cycles   = 0;

    // deframer mirror, reset state
    lpd_phase_t  fr_phase = PH_LEN;
    logic [3:0]  fr_count = '0;
    logic [31:0] fr_len   = '0;
    logic [15:0] fr_type  = '0;
    logic [63:0] fr_id    = '0;
    logic [31:0] fr_left  = '0;
    logic [31:0] fr_max   = MAX_LEN_RESET;

    task automatic deframe_byte(input logic [7:0] b);
        lpd_rec_t beat;
        beat = '0;
        case (fr_phase)
            PH_LEN: begin
                fr_len = {fr_len[23:0], b};
                if (fr_count != LEN_LAST_IDX) begin
                    fr_count = fr_count + 4'd1;
                end else begin
                    fr_count = '0;
                    if (fr_len < MIN_LEN || fr_len > fr_max) begin
                        fr_left  = fr_len;
                        fr_phase = (fr_len != 0) ? PH_SKIP : PH_LEN;
                        fr_len   = '0;
                        beat.kind = KIND_ERROR;
                        beat.last = 1'b1;
                        expected_beats.push_back(beat);
                    end else begin
                        fr_type  = '0;
                        fr_id    = '0;
                        fr_phase = PH_HDR;
                    end
                end
            end
            PH_HDR: begin
                if (fr_count < TYPE_BYTES) begin
                    fr_type = {fr_type[7:0], b};
                end else begin
                    fr_id = {fr_id[55:0], b};
                end
                if (fr_count != HDR_LAST_IDX) begin
                    fr_count = fr_count + 4'd1;
                end else begin
                    fr_count = '0;
                    fr_left  = fr_len - MIN_LEN;
                    fr_len   = '0;
                    fr_phase = (fr_left != 0) ? PH_BODY : PH_LEN;
                    beat.kind        = KIND_HEADER;
                    beat.frame_type  = fr_type;
                    beat.message_id  = fr_id;
                    beat.body_length = fr_left;
                    beat.last        = (fr_left == 0);
                    expected_beats.push_back(beat);
                end
            end
            PH_BODY: begin
                fr_left = fr_left - 32'd1;
                if (fr_left == 0) begin
                    fr_phase = PH_LEN;
                end
                beat.kind      = KIND_BODY;
                beat.data_byte = b;
                beat.last      = (fr_left == 0);
                expected_beats.push_back(beat);
            end
            default: begin
                fr_left = fr_left - 32'd1;
                if (fr_left == 0) begin
                    fr_phase = PH_LEN;
                end
            end
        endcase
    endtask

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata);
                byte_on_bus = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes.pop_front();
                    byte_on_bus = 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
    endtask

    // result monitor
    always @(posedge aclk) begin : result_monitor
        lpd_rec_t got;
        lpd_rec_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[79:16],
                   m_axis_tdata[111:80], m_axis_tdata[119:112], m_axis_tlast};
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual kind %0h tdata %0h last %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind)
                    report_field("kind", 64'(want.kind), 64'(got.kind));
                if (got.frame_type !== want.frame_type)
                    report_field("frame_type", 64'(want.frame_type), 64'(got.frame_type));
                if (got.message_id !== want.message_id)
                    report_field("message_id", want.message_id, got.message_id);
                if (got.body_length !== want.body_length)
                    report_field("body_length", 64'(want.body_length),
                                 64'(got.body_length));
                if (got.data_byte !== want.data_byte)
                    report_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
                if (got.last !== want.last)
                    report_field("last", 64'(want.last), 64'(got.last));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on beats in either direction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_word(input logic [63:0] value, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) begin
            pending_bytes.push_back(value[8*i +: 8]);
        end
    endtask

    // length bytes, then type/id and body, or only skip bytes when short
    task automatic queue_frame(input logic [31:0] len, input logic [15:0] ty,
                               input logic [63:0] id);
        int n;
        queue_word(64'(len), 4);
        if (len >= MIN_LEN) begin
            queue_word(64'(ty), 2);
            queue_word(id, 8);
            n = len - MIN_LEN;
        end else begin
            n = len;
        end
        repeat (n) pending_bytes.push_back(8'($urandom));
    endtask

    task automatic queue_random_frame();
        logic [31:0] len;
        int          r;
        r = $urandom_range(99);
        if (fr_max < MIN_LEN) begin
            len = $urandom_range(0, 40);
        end else if (r < 80) begin
            len = MIN_LEN + ((r < 5) ? $urandom_range(0, 300) : $urandom_range(0, 24));
            if (len > fr_max) begin
                len = fr_max;
            end
        end else if (r < 90 || fr_max >= 1000) begin
            len = $urandom_range(0, 9);
        end else begin
            len = fr_max + $urandom_range(1, 40);
        end
        queue_frame(len, 16'($urandom), {$urandom, $urandom});
    endtask

    task automatic write_max(input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        fr_max = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_bytes.size() != 0 || byte_on_bus || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                write_max(MAX_SETTINGS[p]);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (p == 0) begin
                // zero length, short length with skip, empty body with all-ones header
                queue_frame(32'd0, 16'h0000, 64'h0);
                queue_frame(32'd3, 16'h0000, 64'h0);
                queue_frame(MIN_LEN, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
            end else if (p == 1) begin
                // one above the maximum, then exactly the maximum
                queue_frame(32'd13, 16'h1234, 64'h0123_4567_89AB_CDEF);
                queue_frame(32'd12, 16'h0000, 64'h0);
            end
            while (pending_bytes.size() < PHASE_BYTES) queue_random_frame();
            drain();
        end
        // oversized length left skipping at the end of the stream
        queue_word(64'hFFFF_FFF0, 4);
        drain();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
